// ===== rtl/core/sync_length_crc32_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_LENGTH_CRC32_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CRC32_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SLD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SLD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sld_pkg.sv =====
package sld_pkg;

    localparam logic [31:0] CrcPoly     = 32'hEDB88320;
    localparam logic [31:0] CrcInit     = 32'hFFFFFFFF;
    localparam logic [23:0] SyncReset   = 24'hDC5A5C;
    localparam int          QueueDepth  = 8;
    localparam int          MaxPush     = 3;
    localparam logic [8:0]  LenOffset   = 9'd3;
    localparam logic [7:0]  MinLen      = 8'd4;
    localparam logic [1:0]  WindowFull  = 2'd3;

    // Register index of the sync pattern on the configuration port.
    localparam logic        RegSyncPattern = 1'b0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       first_byte;
        logic       last_byte;
        logic       frame_good;
        logic [8:0] byte_index;
    } result_t;

    typedef struct packed {
        logic [1:0]           cnt;
        result_t [MaxPush-1:0] ent;
    } push_t;

    // One byte of the reflected CRC-32, bit at a time.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CrcPoly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [31:0] HdrCrc1Reset = crc_byte(CrcInit, SyncReset[23:16]);
    localparam logic [31:0] HdrCrc2Reset = crc_byte(HdrCrc1Reset, SyncReset[15:8]);
    localparam logic [31:0] HdrCrcReset  = crc_byte(HdrCrc2Reset, SyncReset[7:0]);

endpackage

// ===== rtl/core/sld_out_queue.sv =====
module sld_out_queue #(
    parameter int Depth = sld_pkg::QueueDepth
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sld_pkg::push_t             push,
    input  logic                       pop,
    output sld_pkg::result_t           head,
    output logic [$clog2(Depth):0]     count
);
    import sld_pkg::*;

    localparam int PtrW = $clog2(Depth);

    result_t               mem [Depth];
    logic [PtrW-1:0]       wr_ptr_reg;
    logic [PtrW-1:0]       wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg;
    logic [PtrW-1:0]       rd_ptr_next;
    logic [PtrW:0]         count_reg;
    logic [PtrW:0]         count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + (PtrW+1)'(push.cnt) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxPush; i++)
        begin
            if (2'(i) < push.cnt)
            begin
                mem[wr_ptr_reg + PtrW'(i)] <= push.ent[i];
            end
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/core/sync_length_crc32_deframer.sv =====
// A result item is written into the output queue and is shown from the queue head.
// Throughput: one input byte per cycle unless in_stall; a sync match puts three header
// bytes into an eight-entry output queue that drains one item per cycle unless out_stall;
// in_stall rises only when downstream stalls leave no room for the next byte's items.
// Reset (rst_n low, asynchronous) empties the queue, restarts the sync hunt and loads
// the sync pattern with its default; there is no clearing pass.
module sync_length_crc32_deframer #(
    parameter int QDepth = sld_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        first_byte,
    output logic        last_byte,
    output logic        frame_good,
    output logic [8:0]  byte_index
);
    import sld_pkg::*;
    `include "sync_length_crc32_deframer_macros.svh"

    localparam int CntW = $clog2(QDepth) + 1;
    localparam logic [CntW-1:0] HuntLimit  = CntW'(QDepth - MaxPush);
    localparam logic [CntW-1:0] FrameLimit = CntW'(QDepth - 1);

    logic [23:0] sync_pattern_reg;
    logic [31:0] hdr_crc_reg;

    logic [23:0] sync_window_reg, sync_window_next;
    logic [1:0]  sync_fill_reg, sync_fill_next;
    logic        in_frame_reg, in_frame_next;
    logic [8:0]  frame_pos_reg, frame_pos_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [31:0] crc_accum_reg, crc_accum_next;
    logic [31:0] crc_received_reg, crc_received_next;

    logic        cfg_write;
    logic        in_accept;
    logic        match;
    logic [23:0] win_shift;
    logic [1:0]  fill_inc;
    logic [7:0]  cur_len;
    logic [31:0] crc_step;
    logic        is_last;
    push_t       push;
    result_t     head;
    logic [CntW-1:0] q_count;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == RegSyncPattern)
        begin
            prdata = {8'd0, sync_pattern_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= SyncReset;
            hdr_crc_reg      <= HdrCrcReset;
        end
        else
        begin
            // The header CRC depends only on the pattern, so it is worked out
            // together with the pattern and is ready for the very next byte.
            if (cfg_write && paddr[2] == RegSyncPattern)
            begin
                sync_pattern_reg <= pwdata[23:0];
                hdr_crc_reg      <= crc_byte(crc_byte(crc_byte(CrcInit, pwdata[23:16]),
                                                      pwdata[15:8]), pwdata[7:0]);
            end
        end
    end

    // A hunting byte may push three items, a frame byte only one.
    assign in_stall  = in_frame_reg ? (q_count > FrameLimit) : (q_count > HuntLimit);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        win_shift = {sync_window_reg[15:0], data_byte};
        fill_inc  = (sync_fill_reg < WindowFull) ? sync_fill_reg + 2'd1 : WindowFull;
        match     = (fill_inc == WindowFull) && (win_shift == sync_pattern_reg);
        cur_len   = (frame_pos_reg == LenOffset) ? data_byte : frame_len_reg;
        crc_step  = crc_byte(crc_accum_reg, data_byte);
        is_last   = frame_pos_reg == ({1'b0, cur_len} + LenOffset);

        sync_window_next  = sync_window_reg;
        sync_fill_next    = sync_fill_reg;
        in_frame_next     = in_frame_reg;
        frame_pos_next    = frame_pos_reg;
        frame_len_next    = frame_len_reg;
        crc_accum_next    = crc_accum_reg;
        crc_received_next = crc_received_reg;
        push              = '0;

        if (in_accept && !in_frame_reg)
        begin
            if (match)
            begin
                push.cnt = 2'(MaxPush);
                push.ent[0] = '{out_byte: win_shift[23:16], first_byte: 1'b1,
                                last_byte: 1'b0, frame_good: 1'b0, byte_index: 9'd0};
                push.ent[1] = '{out_byte: win_shift[15:8], first_byte: 1'b0,
                                last_byte: 1'b0, frame_good: 1'b0, byte_index: 9'd1};
                push.ent[2] = '{out_byte: win_shift[7:0], first_byte: 1'b0,
                                last_byte: 1'b0, frame_good: 1'b0, byte_index: 9'd2};
                sync_window_next  = '0;
                sync_fill_next    = '0;
                in_frame_next     = 1'b1;
                frame_pos_next    = LenOffset;
                frame_len_next    = '0;
                crc_accum_next    = hdr_crc_reg;
                crc_received_next = '0;
            end
            else
            begin
                sync_window_next = win_shift;
                sync_fill_next   = fill_inc;
            end
        end
        else if (in_accept)
        begin
            frame_len_next = cur_len;
            if (frame_pos_reg == LenOffset || frame_pos_reg < {1'b0, frame_len_reg})
            begin
                crc_accum_next = crc_step;
            end
            else
            begin
                crc_received_next = {crc_received_reg[23:0], data_byte};
            end
            push.cnt    = 2'd1;
            push.ent[0] = '{out_byte: data_byte, first_byte: 1'b0, last_byte: is_last,
                            frame_good: is_last && (cur_len >= MinLen)
                                && ((crc_accum_next ^ CrcInit) == crc_received_next),
                            byte_index: frame_pos_reg};
            if (is_last)
            begin
                sync_window_next  = '0;
                sync_fill_next    = '0;
                in_frame_next     = 1'b0;
                frame_pos_next    = '0;
                frame_len_next    = '0;
                crc_accum_next    = CrcInit;
                crc_received_next = '0;
            end
            else
            begin
                frame_pos_next = frame_pos_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_window_reg  <= '0;
            sync_fill_reg    <= '0;
            in_frame_reg     <= 1'b0;
            frame_pos_reg    <= '0;
            frame_len_reg    <= '0;
            crc_accum_reg    <= CrcInit;
            crc_received_reg <= '0;
        end
        else
        begin
            sync_window_reg  <= sync_window_next;
            sync_fill_reg    <= sync_fill_next;
            in_frame_reg     <= in_frame_next;
            frame_pos_reg    <= frame_pos_next;
            frame_len_reg    <= frame_len_next;
            crc_accum_reg    <= crc_accum_next;
            crc_received_reg <= crc_received_next;
        end
    end

    sld_out_queue #(
        .Depth(QDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_valid && !out_stall),
        .head  (head),
        .count (q_count)
    );

    assign out_valid  = q_count != '0;
    assign out_byte   = head.out_byte;
    assign first_byte = head.first_byte;
    assign last_byte  = head.last_byte;
    assign frame_good = head.frame_good;
    assign byte_index = head.byte_index;

    `SLD_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= CntW'(QDepth), "output queue overflow")
    `SLD_ASSERT_NXT(a_frame_end, in_accept && in_frame_reg && is_last, !in_frame_reg,
        "hunt did not restart after the last frame byte")
    `SLD_ASSERT_IMP(a_pos_range, in_frame_reg, frame_pos_reg >= LenOffset && frame_pos_reg <= 9'd258,
        "frame position out of range")
    `SLD_ASSERT_IMP(a_first_index, out_valid && first_byte, byte_index == 9'd0 && !last_byte,
        "first item of a frame has a wrong index")
    `SLD_ASSERT_IMP(a_window_fill, in_frame_reg, sync_fill_reg == 2'd0,
        "sync window not emptied while in a frame")

endmodule
